// ===== rtl/core/pli_pkg.sv =====
`default_nettype none

package pli_pkg;

	localparam int CMD_W  = 2;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int ST_W   = 2;
	localparam int LEN_W  = 5;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [ST_W-1:0]  status_t;

	localparam cmd_t CMD_APPEND = 2'd0;
	localparam cmd_t CMD_INSERT = 2'd1;
	localparam cmd_t CMD_DELETE = 2'd2;
	localparam cmd_t CMD_READ   = 2'd3;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_BADPOS = 2'd2;
	localparam status_t ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/positional_list_insert_delete_core.sv =====
// Channel    Direction  Handshake              Beat contents
// command    in         start high, busy low   command, position, value
// result     out        strobe, one cycle      status, element, last, length
//
// An edit holds busy through S_SHIFT_RD and S_SHIFT_WR for each entry moved, then S_PUT.
// A readout holds busy through S_READ_RD and S_READ_EMIT for each element; a readout of
// an empty list or a rejected edit holds it only through S_EMIT.
// The registered read of the entry memory is why each moved entry is read in
// S_SHIFT_RD and written in S_SHIFT_WR, through the shared index counter.
// Reset clears the element count; entry storage is never cleared.
// The receiver cannot stall; every result beat is shown for exactly one cycle.

`default_nettype none

module positional_list_insert_delete_core #(
	parameter int CAPACITY = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [pli_pkg::CMD_W-1:0]           command,
	input  wire logic [pli_pkg::POS_W-1:0]           position,
	input  wire logic signed [pli_pkg::DATA_W-1:0]   value,
	output logic                                     strobe,
	output logic [pli_pkg::ST_W-1:0]                 status,
	output logic signed [pli_pkg::DATA_W-1:0]        element,
	output logic                                     last,
	output logic [pli_pkg::LEN_W-1:0]                length
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > pli_pkg::POS_W) ? CNT_W : pli_pkg::POS_W) + 1;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_EMIT      = 3'd1;
	localparam logic [2:0] S_SHIFT_RD  = 3'd2;
	localparam logic [2:0] S_SHIFT_WR  = 3'd3;
	localparam logic [2:0] S_PUT       = 3'd4;
	localparam logic [2:0] S_READ_RD   = 3'd5;
	localparam logic [2:0] S_READ_EMIT = 3'd6;

	logic [2:0]                   state_q;
	logic [CNT_W-1:0]             count_q;
	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             stop_q;
	logic                         del_q;
	logic [pli_pkg::DATA_W-1:0]   value_q;
	pli_pkg::status_t             pend_st_q;

	logic                         strobe_q;
	pli_pkg::status_t             status_q;
	logic [pli_pkg::DATA_W-1:0]   element_q;
	logic                         last_q;
	logic [pli_pkg::LEN_W-1:0]    length_q;

	logic [pli_pkg::DATA_W-1:0]   mem_q [CAPACITY];
	logic [pli_pkg::DATA_W-1:0]   rd_data_q;
	logic [IDX_W-1:0]             rd_addr;
	logic                         wr_en;
	logic [pli_pkg::DATA_W-1:0]   wr_data;

	logic [CMP_W-1:0]             pos_c;
	logic [CMP_W-1:0]             cnt_c;
	logic [CMP_W-1:0]             idx_c;
	logic [CMP_W-1:0]             stop_c;
	logic                         full_c;

	assign pos_c  = CMP_W'(position);
	assign cnt_c  = CMP_W'(count_q);
	assign idx_c  = CMP_W'(idx_q);
	assign stop_c = CMP_W'(stop_q);
	assign full_c = (cnt_c >= CMP_W'(CAPACITY));

	always_comb begin
		rd_addr = idx_q;
		if (state_q == S_SHIFT_RD) begin
			rd_addr = del_q ? (idx_q + IDX_W'(1)) : (idx_q - IDX_W'(1));
		end
		wr_en   = (state_q == S_SHIFT_WR) || ((state_q == S_PUT) && !del_q);
		wr_data = (state_q == S_PUT) ? value_q : rd_data_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_q] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			stop_q    <= '0;
			del_q     <= 1'b0;
			pend_st_q <= pli_pkg::ST_OK;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= (state_q == S_EMIT) || (state_q == S_PUT) || (state_q == S_READ_EMIT);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						del_q <= (command == pli_pkg::CMD_DELETE);
						unique case (command)
							pli_pkg::CMD_APPEND: begin
								if (full_c) begin
									pend_st_q <= pli_pkg::ST_FULL;
									state_q   <= S_EMIT;
								end else begin
									idx_q   <= IDX_W'(count_q);
									stop_q  <= IDX_W'(count_q);
									state_q <= S_PUT;
								end
							end
							pli_pkg::CMD_INSERT: begin
								if (full_c) begin
									pend_st_q <= pli_pkg::ST_FULL;
									state_q   <= S_EMIT;
								end else if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
									pend_st_q <= pli_pkg::ST_BADPOS;
									state_q   <= S_EMIT;
								end else begin
									idx_q   <= IDX_W'(count_q);
									stop_q  <= IDX_W'(pos_c - CMP_W'(1));
									state_q <= (pos_c == cnt_c + CMP_W'(1)) ? S_PUT : S_SHIFT_RD;
								end
							end
							pli_pkg::CMD_DELETE: begin
								if (cnt_c == '0) begin
									pend_st_q <= pli_pkg::ST_EMPTY;
									state_q   <= S_EMIT;
								end else if (pos_c == '0 || pos_c > cnt_c) begin
									pend_st_q <= pli_pkg::ST_BADPOS;
									state_q   <= S_EMIT;
								end else begin
									idx_q   <= IDX_W'(pos_c - CMP_W'(1));
									stop_q  <= IDX_W'(pos_c - CMP_W'(1));
									state_q <= (pos_c == cnt_c) ? S_PUT : S_SHIFT_RD;
								end
							end
							pli_pkg::CMD_READ: begin
								if (cnt_c == '0) begin
									pend_st_q <= pli_pkg::ST_EMPTY;
									state_q   <= S_EMIT;
								end else begin
									idx_q   <= '0;
									state_q <= S_READ_RD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_EMIT: begin
					state_q <= S_IDLE;
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (del_q) begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= (idx_c + CMP_W'(2) == cnt_c) ? S_PUT : S_SHIFT_RD;
					end else begin
						idx_q   <= idx_q - IDX_W'(1);
						state_q <= (idx_c - CMP_W'(1) == stop_c) ? S_PUT : S_SHIFT_RD;
					end
				end
				S_PUT: begin
					count_q   <= del_q ? (count_q - CNT_W'(1)) : (count_q + CNT_W'(1));
					pend_st_q <= pli_pkg::ST_OK;
					state_q   <= S_IDLE;
				end
				S_READ_RD: begin
					state_q <= S_READ_EMIT;
				end
				S_READ_EMIT: begin
					if (idx_c + CMP_W'(1) == cnt_c) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_READ_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			value_q <= value;
		end
		unique case (state_q)
			S_EMIT: begin
				status_q  <= pend_st_q;
				element_q <= '0;
				last_q    <= 1'b1;
				length_q  <= pli_pkg::LEN_W'(count_q);
			end
			S_PUT: begin
				status_q  <= pli_pkg::ST_OK;
				element_q <= '0;
				last_q    <= 1'b1;
				length_q  <= del_q ? pli_pkg::LEN_W'(count_q - CNT_W'(1))
				                   : pli_pkg::LEN_W'(count_q + CNT_W'(1));
			end
			S_READ_EMIT: begin
				status_q  <= pli_pkg::ST_OK;
				element_q <= rd_data_q;
				last_q    <= (idx_c + CMP_W'(1) == cnt_c);
				length_q  <= pli_pkg::LEN_W'(count_q);
			end
			default: begin
				status_q  <= status_q;
			end
		endcase
	end

	assign busy    = (state_q != S_IDLE);
	assign strobe  = strobe_q;
	assign status  = status_q;
	assign element = element_q;
	assign last    = last_q;
	assign length  = length_q;

endmodule

`default_nettype wire

// ===== rtl/core/pli_checker.sv =====
`default_nettype none

module pli_checker #(
	parameter int CAPACITY = 16
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                start,
	input wire logic                                busy,
	input wire logic                                strobe,
	input wire logic [pli_pkg::ST_W-1:0]            status,
	input wire logic signed [pli_pkg::DATA_W-1:0]   element,
	input wire logic                                last,
	input wire logic [pli_pkg::LEN_W-1:0]           length
);

	localparam logic [pli_pkg::LEN_W-1:0] FULL_LEN = pli_pkg::LEN_W'(CAPACITY);

	// Every accepted command raises busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// A final beat closes the command, and any other beat has more to follow.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy still high on final result beat");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy && status == pli_pkg::ST_OK)
		else $error("non-final result beat without pending readout");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == pli_pkg::ST_FULL |-> length == FULL_LEN && element == '0)
		else $error("full status with wrong length or element");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == pli_pkg::ST_EMPTY |-> length == '0 && element == '0 && last)
		else $error("empty status with non-empty result");

endmodule

bind positional_list_insert_delete_core pli_checker #(
	.CAPACITY(CAPACITY)
) u_pli_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.strobe(strobe),
	.status(status),
	.element(element),
	.last(last),
	.length(length)
);

`default_nettype wire

// ===== dv/positional_list_insert_delete_core_tb.sv =====
`timescale 1ns / 1ps

module positional_list_insert_delete_core_tb;

	localparam int CAPACITY     = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_GAP      = 14;
	localparam int POS_W        = pli_pkg::POS_W;
	localparam int DATA_W       = pli_pkg::DATA_W;
	localparam int LEN_W        = pli_pkg::LEN_W;

	typedef struct packed {
		pli_pkg::status_t          status;
		logic signed [DATA_W-1:0]  element;
		logic                      last;
		logic [LEN_W-1:0]          length;
	} list_beat_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	pli_pkg::cmd_t             command;
	logic [POS_W-1:0]          position;
	logic signed [DATA_W-1:0]  value;
	logic                      strobe;
	pli_pkg::status_t          status;
	logic signed [DATA_W-1:0]  element;
	logic                      last;
	logic [LEN_W-1:0]          length;

	logic signed [DATA_W-1:0]  shadow_entries [CAPACITY];
	int                        shadow_count;
	list_beat_t                pending_beats [$];
	list_beat_t                expected_beat;
	int                        error_count = 0;
	int                        cycle_count = 0;
	bit                        back_to_back;

	positional_list_insert_delete_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.value(value),
		.strobe(strobe),
		.status(status),
		.element(element),
		.last(last),
		.length(length)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic list_beat_t make_beat(pli_pkg::status_t st,
			logic signed [DATA_W-1:0] elem, logic is_last, int len);
		list_beat_t beat;
		beat.status  = st;
		beat.element = elem;
		beat.last    = is_last;
		beat.length  = len[LEN_W-1:0];
		return beat;
	endfunction

	// Updates the shadow list and queues the beats that one command produces.
	task automatic predict_command(input pli_pkg::cmd_t cmd, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		pli_pkg::status_t st;
		int               at;
		int               i;
		if (cmd == pli_pkg::CMD_READ) begin
			if (shadow_count == 0) begin
				pending_beats.push_back(make_beat(pli_pkg::ST_EMPTY, '0, 1'b1, 0));
			end else begin
				for (i = 0; i < shadow_count; i++)
					pending_beats.push_back(make_beat(pli_pkg::ST_OK, shadow_entries[i],
						i == shadow_count - 1, shadow_count));
			end
			return;
		end
		at = (cmd == pli_pkg::CMD_APPEND) ? shadow_count + 1 : int'(pos);
		if (cmd == pli_pkg::CMD_DELETE) begin
			if (shadow_count == 0) begin
				st = pli_pkg::ST_EMPTY;
			end else if (at < 1 || at > shadow_count) begin
				st = pli_pkg::ST_BADPOS;
			end else begin
				for (i = at - 1; i + 1 < shadow_count; i++)
					shadow_entries[i] = shadow_entries[i + 1];
				shadow_count--;
				st = pli_pkg::ST_OK;
			end
		end else begin
			if (shadow_count >= CAPACITY) begin
				st = pli_pkg::ST_FULL;
			end else if (at < 1 || at > shadow_count + 1) begin
				st = pli_pkg::ST_BADPOS;
			end else begin
				for (i = shadow_count; i >= at; i--)
					shadow_entries[i] = shadow_entries[i - 1];
				shadow_entries[at - 1] = val;
				shadow_count++;
				st = pli_pkg::ST_OK;
			end
		end
		pending_beats.push_back(make_beat(st, '0, 1'b1, shadow_count));
	endtask

	// Drives one command beat and returns at the falling edge after it was taken.
	task automatic send_command(input pli_pkg::cmd_t cmd, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		int gap;
		gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command  = cmd;
		position = pos;
		value    = val;
		start    = 1'b1;
		while (busy)
			@(negedge clk);
		predict_command(cmd, pos, val);
		@(negedge clk);
	endtask

	task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual status %0h element %0h",
					$time, status, element);
				error_count++;
			end else begin
				expected_beat = pending_beats.pop_front();
				compare_field("status", expected_beat.status, status);
				compare_field("element", expected_beat.element, element);
				compare_field("last", expected_beat.last, last);
				compare_field("length", expected_beat.length, length);
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(0, 11))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] random_position(int top);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 8)
			return POS_W'($urandom_range(1, (top < 1) ? 1 : top));
		else if (pick < 9)
			return POS_W'($urandom_range(0, CAPACITY + 1));
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	task automatic test_empty_list();
		send_command(pli_pkg::CMD_READ, 5'd0, random_value());
		send_command(pli_pkg::CMD_DELETE, 5'd1, random_value());
		send_command(pli_pkg::CMD_DELETE, 5'd0, random_value());
		send_command(pli_pkg::CMD_INSERT, 5'd0, 32'sd5);
		send_command(pli_pkg::CMD_INSERT, 5'd2, 32'sd6);
		send_command(pli_pkg::CMD_APPEND, 5'd31, 32'sh7fff_ffff);
	endtask

	task automatic test_directed_edits();
		send_command(pli_pkg::CMD_INSERT, 5'd1, 32'sh8000_0000);
		send_command(pli_pkg::CMD_INSERT, 5'd3, -32'sd1);
		send_command(pli_pkg::CMD_INSERT, 5'd2, '0);
		send_command(pli_pkg::CMD_READ, 5'd17, random_value());
		send_command(pli_pkg::CMD_INSERT, 5'd6, 32'sd7);
		send_command(pli_pkg::CMD_INSERT, 5'd31, 32'sd8);
		send_command(pli_pkg::CMD_DELETE, 5'd5, random_value());
		send_command(pli_pkg::CMD_DELETE, 5'd0, random_value());
		send_command(pli_pkg::CMD_DELETE, 5'd1, random_value());
		send_command(pli_pkg::CMD_DELETE, 5'd3, random_value());
		send_command(pli_pkg::CMD_DELETE, 5'd2, random_value());
		send_command(pli_pkg::CMD_READ, 5'd0, random_value());
	endtask

	task automatic test_full_list();
		while (shadow_count < CAPACITY) begin
			if ($urandom_range(0, 1))
				send_command(pli_pkg::CMD_APPEND, random_position(CAPACITY + 1),
					random_value());
			else
				send_command(pli_pkg::CMD_INSERT, random_position(shadow_count + 1),
					random_value());
		end
		send_command(pli_pkg::CMD_READ, 5'd0, random_value());
		send_command(pli_pkg::CMD_APPEND, 5'd0, random_value());
		send_command(pli_pkg::CMD_INSERT, 5'd1, random_value());
		send_command(pli_pkg::CMD_INSERT, 5'd17, random_value());
		send_command(pli_pkg::CMD_INSERT, 5'd18, random_value());
		send_command(pli_pkg::CMD_INSERT, 5'd0, random_value());
		send_command(pli_pkg::CMD_DELETE, 5'd17, random_value());
		send_command(pli_pkg::CMD_DELETE, 5'd16, random_value());
		send_command(pli_pkg::CMD_INSERT, 5'd16, random_value());
		send_command(pli_pkg::CMD_READ, 5'd31, random_value());
		while (shadow_count > 0) begin
			if ($urandom_range(0, 5) == 0)
				send_command(pli_pkg::CMD_READ, random_position(CAPACITY), random_value());
			send_command(pli_pkg::CMD_DELETE, random_position(shadow_count), random_value());
		end
		send_command(pli_pkg::CMD_READ, random_position(CAPACITY), random_value());
	endtask

	task automatic test_random_mix(input int items);
		int  k;
		int  pick;
		bit  grow;
		grow = 1'b1;
		for (k = 0; k < items; k++) begin
			if ($urandom_range(0, 29) == 0)
				back_to_back = !back_to_back;
			if ($urandom_range(0, 39) == 0)
				grow = !grow;
			pick = $urandom_range(0, 99);
			if (pick < 12)
				send_command(pli_pkg::CMD_READ, random_position(CAPACITY + 1),
					random_value());
			else if (pick < (grow ? 40 : 25))
				send_command(pli_pkg::CMD_APPEND, random_position(CAPACITY + 1),
					random_value());
			else if (pick < (grow ? 68 : 38))
				send_command(pli_pkg::CMD_INSERT, random_position(shadow_count + 1),
					random_value());
			else
				send_command(pli_pkg::CMD_DELETE, random_position(shadow_count),
					random_value());
		end
		back_to_back = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = pli_pkg::CMD_APPEND;
		position     = '0;
		value        = '0;
		shadow_count = 0;
		back_to_back = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_list();
		test_directed_edits();
		test_full_list();
		test_random_mix(400);

		start = 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
